// ----- hw/rtl/assert_macros.svh -----
// assert_macros.svh: assertion macros shared by the RTL of the line renderer.
// Needs a clock and a reset signal named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is high
`define TLCR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included
`define TLCR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/tlcr_pkg.sv -----
// tlcr_pkg: types and constants of the text line character renderer.
// No dependencies; imported by text_line_char_renderer.
package tlcr_pkg;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_RUN,
      ST_FLUSH
   } state_type;

   // Request action codes
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_PUT   = 2'd1;
   localparam logic [1:0] ACT_ERASE = 2'd2;

   // Result kinds
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FILL  = 1'b1;

   // Register indexes
   localparam logic REG_LINE_WIDTH = 1'b0;
   localparam logic REG_TAB_SIZE   = 1'b1;

   // Register reset values
   localparam logic [7:0] LINE_WIDTH_RST = 8'd80;
   localparam logic [4:0] TAB_SIZE_RST   = 5'd8;

   // Largest tab distance honoured
   localparam logic [4:0] TAB_LIMIT = 5'd16;

   // Cursor saturation point
   localparam logic [15:0] COL_MAX = 16'h7FFF;

   // Character codes
   localparam logic [6:0] CH_TAB   = 7'h09;
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_DEL   = 7'h7F;
   localparam logic [6:0] CH_FLIP  = 7'h40;
   localparam logic [6:0] CH_GT    = 7'h3E;
   localparam logic [6:0] CH_CARET = 7'h5E;

endpackage

// ----- hw/rtl/tlcr_if.sv -----
// tlcr_if: valid/ready channel interfaces of the line renderer (request and result).
// No dependencies.
interface tlcr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [6:0]  char_code;
   logic [14:0] scroll_offset;

   modport source (output valid, output action, output char_code, output scroll_offset,
                   input ready);
   modport sink   (input valid, input action, input char_code, input scroll_offset,
                   output ready);
endinterface

interface tlcr_rsp_if;
   logic       valid;
   logic       ready;
   logic       op_kind;
   logic [7:0] column;
   logic [6:0] glyph;
   logic       last;

   modport source (output valid, output op_kind, output column, output glyph, output last,
                   input ready);
   modport sink   (input valid, input op_kind, input column, input glyph, input last,
                   output ready);
endinterface

// ----- hw/rtl/text_line_char_renderer.sv -----
// text_line_char_renderer: renders 7-bit text into one screen line as write/fill results.
// Depends on tlcr_pkg, tlcr_if.sv (tlcr_req_if, tlcr_rsp_if) and assert_macros.svh.
//
// One request is handled at a time; req_chan.ready is high only while the sequencer is idle.
// A start request gives no result. A printable character or an erase goes through accept,
// render and flush of the final result; a control character may take an extra render step.
// A tab renders spaces up to the next tab stop, and when the tab phase is unknown (after
// a tab_size write or an erase) it first runs a bit-serial remainder unit that
// recomputes the logical column modulo the tab size. Every result passes through a one-deep
// hold stage so the final one can be flagged last, and then an output register; back-pressure
// on rsp_chan stalls the sequencer.
`include "assert_macros.svh"

module text_line_char_renderer
   import tlcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tlcr_req_if.sink    req_chan,
   tlcr_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   // Control and line state
   state_type   state_ff, state_in;
   logic [15:0] cur_ff, cur_in;          // cursor column, two's complement
   logic [14:0] off_ff, off_in;
   logic [3:0]  phase_ff, phase_in;
   logic        stale_ff, stale_in;      // phase needs recomputing
   logic [7:0]  lw_ff, lw_in;
   logic [4:0]  ts_ff, ts_in;

   // Current transaction
   logic [1:0]  act_ff, act_in;
   logic [6:0]  chr_ff, chr_in;
   logic        tab_ff, tab_in;
   logic        ctl_ff, ctl_in;
   logic [4:0]  cnt_ff, cnt_in;

   // Remainder unit
   logic [15:0] div_ff, div_in;
   logic [3:0]  rem_ff, rem_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;

   // Hold stage
   logic        hold_valid_ff, hold_valid_in;
   logic        hold_kind_ff, hold_kind_in;
   logic [7:0]  hold_col_ff, hold_col_in;
   logic [6:0]  hold_glyph_ff, hold_glyph_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_col_ff, rsp_col_in;
   logic [6:0]  rsp_glyph_ff, rsp_glyph_in;
   logic        rsp_last_ff, rsp_last_in;

   // Helpers
   logic [7:0]  w_eff;
   logic [4:0]  tab_eff;
   logic        past_edge, cur_neg, cur_sat, phase_wrap, out_free;
   logic [15:0] cur_inc, logical;
   logic [3:0]  phase_inc;
   logic [4:0]  rem_sh, rem_sub, cnt_inc;
   logic [3:0]  rem_next;
   logic [6:0]  glyph_sel;
   logic        st_emit, st_kind, st_done;
   logic [7:0]  st_col;
   logic [6:0]  st_glyph;

   // Effective register values
   assign w_eff   = (lw_ff == 8'd0) ? 8'd1 : lw_ff;
   assign tab_eff = (ts_ff == 5'd0) ? 5'd1 : ((ts_ff > TAB_LIMIT) ? TAB_LIMIT : ts_ff);

   // Cursor arithmetic
   assign cur_neg    = cur_ff[15];
   assign past_edge  = $signed(cur_ff) >= $signed({8'd0, w_eff});
   assign cur_sat    = (cur_ff == COL_MAX);
   assign cur_inc    = cur_sat ? cur_ff : 16'(cur_ff + 16'd1);
   assign phase_wrap = (5'({1'b0, phase_ff} + 5'd1) == tab_eff);
   assign phase_inc  = (cur_sat || stale_ff) ? phase_ff :
                       (phase_wrap ? 4'd0 : 4'(phase_ff + 4'd1));
   assign logical    = 16'(cur_ff + {1'b0, off_ff});
   assign cnt_inc    = 5'(cnt_ff + 5'd1);

   // Remainder step: one dividend bit per cycle
   assign rem_sh   = {rem_ff, div_ff[15]};
   assign rem_sub  = 5'(rem_sh - tab_eff);
   assign rem_next = (rem_sh >= tab_eff) ? rem_sub[3:0] : rem_sh[3:0];

   assign glyph_sel = tab_ff ? CH_SPACE : (ctl_ff ? CH_CARET : chr_ff);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   // Render step for the current glyph or erase
   always_comb begin
      if (act_ff == ACT_ERASE) begin
         st_emit  = !past_edge;
         st_kind  = OP_FILL;
         st_col   = cur_neg ? 8'd0 : cur_ff[7:0];
         st_glyph = CH_SPACE;
         st_done  = 1'b1;
      end else begin
         st_emit  = past_edge || !cur_neg;
         st_kind  = OP_WRITE;
         st_col   = past_edge ? 8'(w_eff - 8'd1) : cur_ff[7:0];
         st_glyph = past_edge ? CH_GT : glyph_sel;
         if (tab_ff) begin
            st_done = !((phase_inc != 4'd0) && (cnt_inc < tab_eff));
         end else if (ctl_ff) begin
            st_done = past_edge;
         end else begin
            st_done = 1'b1;
         end
      end
   end

   // Sequencer, next state and outputs
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      off_in        = off_ff;
      phase_in      = phase_ff;
      stale_in      = stale_ff;
      lw_in         = lw_ff;
      ts_in         = ts_ff;
      act_in        = act_ff;
      chr_in        = chr_ff;
      tab_in        = tab_ff;
      ctl_in        = ctl_ff;
      cnt_in        = cnt_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      hold_valid_in = hold_valid_ff;
      hold_kind_in  = hold_kind_ff;
      hold_col_in   = hold_col_ff;
      hold_glyph_in = hold_glyph_ff;
      rsp_valid_in  = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_glyph_in  = rsp_glyph_ff;
      rsp_last_in   = rsp_last_ff;
      req_chan.ready = (state_ff == ST_IDLE);

      // Register writes; a new tab size invalidates the phase
      if (csr_we) begin
         case (csr_index)
            REG_LINE_WIDTH: lw_in = csr_wdata;
            REG_TAB_SIZE: begin
               ts_in    = csr_wdata[4:0];
               stale_in = 1'b1;
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.action)
                  ACT_START: begin
                     cur_in   = 16'(16'd0 - {1'b0, req_chan.scroll_offset});
                     off_in   = req_chan.scroll_offset;
                     phase_in = 4'd0;
                     stale_in = 1'b0;
                  end
                  ACT_PUT: begin
                     act_in     = ACT_PUT;
                     chr_in     = req_chan.char_code;
                     tab_in     = (req_chan.char_code == CH_TAB);
                     ctl_in     = ((req_chan.char_code < CH_SPACE) &&
                                   (req_chan.char_code != CH_TAB)) ||
                                  (req_chan.char_code == CH_DEL);
                     cnt_in     = 5'd0;
                     div_in     = logical;
                     rem_in     = 4'd0;
                     bit_cnt_in = 4'd0;
                     if ((req_chan.char_code == CH_TAB) && stale_ff) begin
                        state_in = ST_MOD;
                     end else begin
                        state_in = ST_RUN;
                     end
                  end
                  ACT_ERASE: begin
                     act_in   = ACT_ERASE;
                     tab_in   = 1'b0;
                     ctl_in   = 1'b0;
                     state_in = ST_RUN;
                  end
                  default: ;
               endcase
            end
         end

         // Logical column modulo tab size, MSB first
         ST_MOD: begin
            rem_in     = rem_next;
            div_in     = {div_ff[14:0], 1'b0};
            bit_cnt_in = 4'(bit_cnt_ff + 4'd1);
            if (bit_cnt_ff == 4'd15) begin
               phase_in = rem_next;
               stale_in = 1'b0;
               state_in = ST_RUN;
            end
         end

         ST_RUN: begin
            if (out_free) begin
               // Cursor and phase update
               if (act_ff == ACT_ERASE) begin
                  if (!past_edge) begin
                     cur_in   = {8'd0, w_eff};
                     stale_in = 1'b1;
                  end
               end else begin
                  cur_in   = cur_inc;
                  phase_in = phase_inc;
                  cnt_in   = cnt_inc;
                  if (ctl_ff && !past_edge) begin
                     ctl_in = 1'b0;
                     chr_in = chr_ff ^ CH_FLIP;
                  end
               end
               // New result displaces the held one to the output register
               if (st_emit) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = hold_kind_ff;
                     rsp_col_in   = hold_col_ff;
                     rsp_glyph_in = hold_glyph_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_kind_in  = st_kind;
                  hold_col_in   = st_col;
                  hold_glyph_in = st_glyph;
               end
               if (st_done) begin
                  state_in = ST_FLUSH;
               end
            end
         end

         // Release the final result flagged last
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = hold_kind_ff;
               rsp_col_in    = hold_col_ff;
               rsp_glyph_in  = hold_glyph_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_ff        <= 16'd0;
         off_ff        <= 15'd0;
         phase_ff      <= 4'd0;
         stale_ff      <= 1'b0;
         lw_ff         <= LINE_WIDTH_RST;
         ts_ff         <= TAB_SIZE_RST;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         off_ff        <= off_in;
         phase_ff      <= phase_in;
         stale_ff      <= stale_in;
         lw_ff         <= lw_in;
         ts_ff         <= ts_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      chr_ff        <= chr_in;
      tab_ff        <= tab_in;
      ctl_ff        <= ctl_in;
      cnt_ff        <= cnt_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      bit_cnt_ff    <= bit_cnt_in;
      hold_kind_ff  <= hold_kind_in;
      hold_col_ff   <= hold_col_in;
      hold_glyph_ff <= hold_glyph_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_glyph_ff  <= rsp_glyph_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.op_kind = rsp_kind_ff;
   assign rsp_chan.column  = rsp_col_ff;
   assign rsp_chan.glyph   = rsp_glyph_ff;
   assign rsp_chan.last    = rsp_last_ff;

   // Checks
   `TLCR_ASSERT(a_idle_no_hold, (state_ff == ST_IDLE) |-> !hold_valid_ff, "held result left in idle")
   `TLCR_ASSERT(a_phase_range, !stale_ff |-> ({1'b0, phase_ff} < tab_eff), "tab phase out of range")
   `TLCR_ASSERT(a_mod_for_tab, (state_ff == ST_MOD) |-> tab_ff, "remainder unit run for non-tab")
   `TLCR_ASSERT(a_col_in_line, rsp_valid_ff |-> (rsp_col_ff < w_eff), "result column past line end")

endmodule
